FILE: rtl/ril_pkg.sv
package ril_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;              // coordinate and matrix entry
    localparam int IDX_W     = 16;              // correspondence index
    localparam int THR_W     = 31;              // distance threshold
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Internal widths
    localparam int PW    = 2 * CW;              // 32x32 product
    localparam int XW    = PW + 1;              // projected x, y, w
    localparam int LW    = 32;                  // limb of a split multiply
    localparam int PRW   = CW + LW + 1;         // coordinate times one limb of w
    localparam int TWW   = THR_W + LW;          // threshold times one limb of |w|
    localparam int EW    = 97;                  // signed reprojection error
    localparam int EXW   = EW + 1;              // error before truncation
    localparam int MW    = 96;                  // magnitude of error and of t*|w|
    localparam int NLIMB = MW / LW;             // limbs per magnitude
    localparam int NSQ   = 3;                   // squares: ex, ey and t*|w|
    localparam int SQW   = 2 * MW;              // a square
    localparam int LHSW  = SQW + 1;             // sum of two squares

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(66);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_P_ROW0_COLS01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_P_ROW0_COLS23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P_ROW1_COLS01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P_ROW1_COLS23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_P_ROW2_COLS01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_P_ROW2_COLS23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INLIER_THRESHOLD = 3'd6;

    // Camera matrix: three rows of four entries
    typedef logic [3:0][CW-1:0] t_row;
    typedef t_row [2:0]         t_mat;

    // Sideband that travels with every item
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_tag;

    // One correspondence
    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic signed [CW-1:0] image_u;
        logic signed [CW-1:0] image_v;
        t_tag                 tag;
    } t_pt;

    // Projected point with observation
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] w;
        logic signed [CW-1:0] image_u;
        logic signed [CW-1:0] image_v;
        t_tag                 tag;
    } t_proj;

    // Magnitudes to be squared, plus zero-w flag
    typedef struct packed {
        logic [NSQ-1:0][MW-1:0] mag;    // |ex|, |ey|, t*|w|
        logic                   w_zero;
        t_tag                   tag;
    } t_err;

endpackage

FILE: rtl/ril_pt_if.sv
interface ril_pt_if;
    logic                         valid;
    logic                         ready;
    logic signed [ril_pkg::CW-1:0] point_x;
    logic signed [ril_pkg::CW-1:0] point_y;
    logic signed [ril_pkg::CW-1:0] point_z;
    logic signed [ril_pkg::CW-1:0] image_u;
    logic signed [ril_pkg::CW-1:0] image_v;
    logic [ril_pkg::IDX_W-1:0]     item_index;
    logic                         last_item;

    modport source (
        output valid, point_x, point_y, point_z, image_u, image_v, item_index, last_item,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, image_u, image_v, item_index, last_item,
        output ready
    );
endinterface

FILE: rtl/ril_res_if.sv
interface ril_res_if;
    logic                     valid;
    logic                     ready;
    logic [ril_pkg::IDX_W-1:0] result_index;
    logic                     is_inlier;
    logic                     result_last;

    modport source (
        output valid, result_index, is_inlier, result_last,
        input  ready
    );
    modport sink (
        input  valid, result_index, is_inlier, result_last,
        output ready
    );
endinterface

FILE: rtl/ril_project.sv
module ril_project (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ril_pkg::t_pt   i_pt,
    input  ril_pkg::t_mat  i_mat,
    output logic           o_valid,
    input  logic           i_dn_ready,
    output ril_pkg::t_proj o_proj
);

    logic signed [ril_pkg::CW-1:0] coord [3];
    logic signed [ril_pkg::PW-1:0] n_prod [3][3];
    logic signed [ril_pkg::XW-1:0] n_sum [3];

    logic                          r_s1_v;
    logic signed [ril_pkg::PW-1:0] r_s1_prod [3][3];
    logic signed [ril_pkg::CW-1:0] r_s1_u;
    logic signed [ril_pkg::CW-1:0] r_s1_vc;
    ril_pkg::t_tag                 r_s1_tag;

    logic           r_s2_v;
    ril_pkg::t_proj r_s2;

    logic en1, en2;

    // Advance a stage when it is empty or its successor advances
    assign en2     = !r_s2_v || i_dn_ready;
    assign en1     = !r_s1_v || en2;
    assign o_ready = en1;

    // Stage 1: the nine entry-times-coordinate products
    always_comb begin
        coord[0] = i_pt.point_x;
        coord[1] = i_pt.point_y;
        coord[2] = i_pt.point_z;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = $signed(i_mat[r][c]) * coord[c];
            end
        end
    end

    // Stage 2: sum the products and the translation column scaled by one
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = ril_pkg::XW'(r_s1_prod[r][0]) + ril_pkg::XW'(r_s1_prod[r][1])
                     + ril_pkg::XW'(r_s1_prod[r][2])
                     + (ril_pkg::XW'($signed(i_mat[r][3])) <<< ril_pkg::FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (en1) r_s1_v <= i_valid;
            if (en2) r_s2_v <= r_s1_v;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_prod <= n_prod;
            r_s1_u    <= i_pt.image_u;
            r_s1_vc   <= i_pt.image_v;
            r_s1_tag  <= i_pt.tag;
        end
        if (en2) begin
            r_s2.x       <= n_sum[0];
            r_s2.y       <= n_sum[1];
            r_s2.w       <= n_sum[2];
            r_s2.image_u <= r_s1_u;
            r_s2.image_v <= r_s1_vc;
            r_s2.tag     <= r_s1_tag;
        end
    end

    assign o_valid = r_s2_v;
    assign o_proj  = r_s2;

endmodule

FILE: rtl/ril_error.sv
module ril_error (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  ril_pkg::t_proj              i_proj,
    input  logic [ril_pkg::THR_W-1:0]   i_thr,
    output logic                        o_valid,
    input  logic                        i_dn_ready,
    output ril_pkg::t_err               o_err
);

    // Stage 3: w split into an unsigned low limb and a signed high limb
    logic signed [ril_pkg::XW-ril_pkg::LW-1:0] w_hi;
    logic signed [ril_pkg::LW:0]               w_lo;

    logic                           r_s3_v;
    logic signed [ril_pkg::XW-1:0]  r_s3_x;
    logic signed [ril_pkg::XW-1:0]  r_s3_y;
    logic signed [ril_pkg::PRW-1:0] r_s3_uwl;
    logic signed [ril_pkg::PRW-1:0] r_s3_uwh;
    logic signed [ril_pkg::PRW-1:0] r_s3_vwl;
    logic signed [ril_pkg::PRW-1:0] r_s3_vwh;
    logic [ril_pkg::PW-1:0]         r_s3_aw;
    logic                           r_s3_wz;
    ril_pkg::t_tag                  r_s3_tag;

    logic signed [ril_pkg::EXW-1:0] n_ex_full;
    logic signed [ril_pkg::EXW-1:0] n_ey_full;

    logic                           r_s4_v;
    logic signed [ril_pkg::EW-1:0]  r_s4_ex;
    logic signed [ril_pkg::EW-1:0]  r_s4_ey;
    logic [ril_pkg::TWW-1:0]        r_s4_twl;
    logic [ril_pkg::TWW-1:0]        r_s4_twh;
    logic                           r_s4_wz;
    ril_pkg::t_tag                  r_s4_tag;

    logic          r_s5_v;
    ril_pkg::t_err r_s5;

    logic en3, en4, en5;

    assign en5     = !r_s5_v || i_dn_ready;
    assign en4     = !r_s4_v || en5;
    assign en3     = !r_s3_v || en4;
    assign o_ready = en3;

    assign w_hi = i_proj.w[ril_pkg::XW-1:ril_pkg::LW];
    assign w_lo = $signed({1'b0, i_proj.w[ril_pkg::LW-1:0]});

    // Stage 4: error terms x*one - u*w, y*one - v*w
    always_comb begin
        n_ex_full = (ril_pkg::EXW'(r_s3_x) <<< ril_pkg::FRAC_BITS)
                  - (ril_pkg::EXW'(r_s3_uwh) <<< ril_pkg::LW)
                  - ril_pkg::EXW'(r_s3_uwl);
        n_ey_full = (ril_pkg::EXW'(r_s3_y) <<< ril_pkg::FRAC_BITS)
                  - (ril_pkg::EXW'(r_s3_vwh) <<< ril_pkg::LW)
                  - ril_pkg::EXW'(r_s3_vwl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (en3) r_s3_v <= i_valid;
            if (en4) r_s4_v <= r_s3_v;
            if (en5) r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 3: limb products of u, v with w; magnitude of w
        if (en3) begin
            r_s3_x   <= i_proj.x;
            r_s3_y   <= i_proj.y;
            r_s3_uwl <= i_proj.image_u * w_lo;
            r_s3_uwh <= i_proj.image_u * w_hi;
            r_s3_vwl <= i_proj.image_v * w_lo;
            r_s3_vwh <= i_proj.image_v * w_hi;
            r_s3_aw  <= i_proj.w[ril_pkg::XW-1] ? ril_pkg::PW'(-i_proj.w)
                                                : i_proj.w[ril_pkg::PW-1:0];
            r_s3_wz  <= (i_proj.w == '0);
            r_s3_tag <= i_proj.tag;
        end
        // Stage 4: error terms; threshold times each limb of |w|
        if (en4) begin
            r_s4_ex  <= n_ex_full[ril_pkg::EW-1:0];
            r_s4_ey  <= n_ey_full[ril_pkg::EW-1:0];
            r_s4_twl <= ril_pkg::TWW'(i_thr) * ril_pkg::TWW'(r_s3_aw[ril_pkg::LW-1:0]);
            r_s4_twh <= ril_pkg::TWW'(i_thr)
                      * ril_pkg::TWW'(r_s3_aw[ril_pkg::PW-1:ril_pkg::LW]);
            r_s4_wz  <= r_s3_wz;
            r_s4_tag <= r_s3_tag;
        end
        // Stage 5: magnitudes of the errors; assemble t*|w|
        if (en5) begin
            r_s5.mag[0] <= r_s4_ex[ril_pkg::EW-1] ? ril_pkg::MW'(-r_s4_ex)
                                                  : r_s4_ex[ril_pkg::MW-1:0];
            r_s5.mag[1] <= r_s4_ey[ril_pkg::EW-1] ? ril_pkg::MW'(-r_s4_ey)
                                                  : r_s4_ey[ril_pkg::MW-1:0];
            r_s5.mag[2] <= ril_pkg::MW'(r_s4_twl)
                         + (ril_pkg::MW'(r_s4_twh) << ril_pkg::LW);
            r_s5.w_zero <= r_s4_wz;
            r_s5.tag    <= r_s4_tag;
        end
    end

    assign o_valid = r_s5_v;
    assign o_err   = r_s5;

endmodule

FILE: rtl/ril_square_cmp.sv
module ril_square_cmp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ril_pkg::t_err i_err,
    output logic          o_valid,
    input  logic          i_dn_ready,
    output ril_pkg::t_tag o_tag,
    output logic          o_inlier
);

    // Limb products per square: diagonal a0a0, a1a1, a2a2;
    // cross a0a1, a0a2, a1a2
    logic [ril_pkg::PW-1:0] n_d [ril_pkg::NSQ][ril_pkg::NLIMB];
    logic [ril_pkg::PW-1:0] n_c [ril_pkg::NSQ][3];
    logic [ril_pkg::SQW-1:0] n_sq [ril_pkg::NSQ];

    logic                   r_s6_v;
    logic [ril_pkg::PW-1:0] r_s6_d [ril_pkg::NSQ][ril_pkg::NLIMB];
    logic [ril_pkg::PW-1:0] r_s6_c [ril_pkg::NSQ][3];
    logic                   r_s6_wz;
    ril_pkg::t_tag          r_s6_tag;

    logic                    r_s7_v;
    logic [ril_pkg::SQW-1:0] r_s7_sq [ril_pkg::NSQ];
    logic                    r_s7_wz;
    ril_pkg::t_tag           r_s7_tag;

    logic                     r_s8_v;
    logic [ril_pkg::LHSW-1:0] r_s8_lhs;
    logic [ril_pkg::SQW-1:0]  r_s8_rhs;
    logic                     r_s8_wz;
    ril_pkg::t_tag            r_s8_tag;

    logic          r_s9_v;
    logic          r_s9_inl;
    ril_pkg::t_tag r_s9_tag;

    logic en6, en7, en8, en9;

    assign en9     = !r_s9_v || i_dn_ready;
    assign en8     = !r_s8_v || en9;
    assign en7     = !r_s7_v || en8;
    assign en6     = !r_s6_v || en7;
    assign o_ready = en6;

    // Stage 6: 32x32 limb products of each magnitude
    always_comb begin
        for (int k = 0; k < ril_pkg::NSQ; k++) begin
            for (int j = 0; j < ril_pkg::NLIMB; j++) begin
                n_d[k][j] = ril_pkg::PW'(i_err.mag[k][ril_pkg::LW*j +: ril_pkg::LW])
                          * ril_pkg::PW'(i_err.mag[k][ril_pkg::LW*j +: ril_pkg::LW]);
            end
            n_c[k][0] = ril_pkg::PW'(i_err.mag[k][0 +: ril_pkg::LW])
                      * ril_pkg::PW'(i_err.mag[k][ril_pkg::LW +: ril_pkg::LW]);
            n_c[k][1] = ril_pkg::PW'(i_err.mag[k][0 +: ril_pkg::LW])
                      * ril_pkg::PW'(i_err.mag[k][2*ril_pkg::LW +: ril_pkg::LW]);
            n_c[k][2] = ril_pkg::PW'(i_err.mag[k][ril_pkg::LW +: ril_pkg::LW])
                      * ril_pkg::PW'(i_err.mag[k][2*ril_pkg::LW +: ril_pkg::LW]);
        end
    end

    // Stage 7: diagonals sit side by side, a0a1 and a1a2 too; doubling is a shift
    always_comb begin
        for (int k = 0; k < ril_pkg::NSQ; k++) begin
            n_sq[k] = {r_s6_d[k][2], r_s6_d[k][1], r_s6_d[k][0]}
                    + (ril_pkg::SQW'({r_s6_c[k][2], r_s6_c[k][0]}) << (ril_pkg::LW + 1))
                    + (ril_pkg::SQW'(r_s6_c[k][1]) << (2*ril_pkg::LW + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
            r_s9_v <= 1'b0;
        end else begin
            if (en6) r_s6_v <= i_valid;
            if (en7) r_s7_v <= r_s6_v;
            if (en8) r_s8_v <= r_s7_v;
            if (en9) r_s9_v <= r_s8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_s6_d   <= n_d;
            r_s6_c   <= n_c;
            r_s6_wz  <= i_err.w_zero;
            r_s6_tag <= i_err.tag;
        end
        if (en7) begin
            r_s7_sq  <= n_sq;
            r_s7_wz  <= r_s6_wz;
            r_s7_tag <= r_s6_tag;
        end
        // Stage 8: squared error on the left, (t*|w|)^2 on the right
        if (en8) begin
            r_s8_lhs <= ril_pkg::LHSW'(r_s7_sq[0]) + ril_pkg::LHSW'(r_s7_sq[1]);
            r_s8_rhs <= r_s7_sq[2];
            r_s8_wz  <= r_s7_wz;
            r_s8_tag <= r_s7_tag;
        end
        // Stage 9: compare; zero w is never an inlier
        if (en9) begin
            r_s9_inl <= !r_s8_wz && (r_s8_lhs < ril_pkg::LHSW'(r_s8_rhs));
            r_s9_tag <= r_s8_tag;
        end
    end

    assign o_valid  = r_s9_v;
    assign o_tag    = r_s9_tag;
    assign o_inlier = r_s9_inl;

endmodule

FILE: rtl/reprojection_inlier_test.sv
// Reprojection inlier test, nine register stages.
// Throughput: one item per cycle while the output is not stalled; each stage
// advances when empty or drained, so bubbles collapse and a stalled output
// still lets the pipe fill behind it.
// Reset (synchronous, active low) empties the pipe, clears the camera matrix
// and loads the threshold with 66.
module reprojection_inlier_test (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ril_pt_if.sink                          i_pt,
    ril_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [ril_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ril_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    ril_pkg::t_mat               r_mat;
    ril_pkg::t_mat               n_mat;
    logic [ril_pkg::THR_W-1:0]   r_thr;
    logic [ril_pkg::THR_W-1:0]   n_thr;

    ril_pkg::t_pt   pt;
    ril_pkg::t_proj proj;
    ril_pkg::t_err  err;
    ril_pkg::t_tag  res_tag;
    logic           proj_valid, proj_ready;
    logic           err_valid, err_ready;

    // Decode configuration writes; unknown indexes are dropped
    always_comb begin
        n_mat = r_mat;
        n_thr = r_thr;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                ril_pkg::CFG_P_ROW0_COLS01: begin
                    n_mat[0][0] = i_cfg_data[31:0];
                    n_mat[0][1] = i_cfg_data[63:32];
                end
                ril_pkg::CFG_P_ROW0_COLS23: begin
                    n_mat[0][2] = i_cfg_data[31:0];
                    n_mat[0][3] = i_cfg_data[63:32];
                end
                ril_pkg::CFG_P_ROW1_COLS01: begin
                    n_mat[1][0] = i_cfg_data[31:0];
                    n_mat[1][1] = i_cfg_data[63:32];
                end
                ril_pkg::CFG_P_ROW1_COLS23: begin
                    n_mat[1][2] = i_cfg_data[31:0];
                    n_mat[1][3] = i_cfg_data[63:32];
                end
                ril_pkg::CFG_P_ROW2_COLS01: begin
                    n_mat[2][0] = i_cfg_data[31:0];
                    n_mat[2][1] = i_cfg_data[63:32];
                end
                ril_pkg::CFG_P_ROW2_COLS23: begin
                    n_mat[2][2] = i_cfg_data[31:0];
                    n_mat[2][3] = i_cfg_data[63:32];
                end
                ril_pkg::CFG_INLIER_THRESHOLD: begin
                    n_thr = i_cfg_data[ril_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
            r_thr <= ril_pkg::THR_RESET;
        end else begin
            r_mat <= n_mat;
            r_thr <= n_thr;
        end
    end

    // Gather the input transfer into one word
    always_comb begin
        pt.point_x  = i_pt.point_x;
        pt.point_y  = i_pt.point_y;
        pt.point_z  = i_pt.point_z;
        pt.image_u  = i_pt.image_u;
        pt.image_v  = i_pt.image_v;
        pt.tag.idx  = i_pt.item_index;
        pt.tag.last = i_pt.last_item;
    end

    ril_project u_project (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_pt.valid),
        .o_ready    (i_pt.ready),
        .i_pt       (pt),
        .i_mat      (r_mat),
        .o_valid    (proj_valid),
        .i_dn_ready (proj_ready),
        .o_proj     (proj)
    );

    ril_error u_error (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (proj_valid),
        .o_ready    (proj_ready),
        .i_proj     (proj),
        .i_thr      (r_thr),
        .o_valid    (err_valid),
        .i_dn_ready (err_ready),
        .o_err      (err)
    );

    ril_square_cmp u_square_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (err_valid),
        .o_ready    (err_ready),
        .i_err      (err),
        .o_valid    (o_res.valid),
        .i_dn_ready (o_res.ready),
        .o_tag      (res_tag),
        .o_inlier   (o_res.is_inlier)
    );

    assign o_res.result_index = res_tag.idx;
    assign o_res.result_last  = res_tag.last;

endmodule
